>>> rtl/sfd_pkg.sv
// Shared widths for the spring force pipeline.
package sfd_pkg;
  localparam int LANES  = 3;
  localparam int D_W    = 33;   // position difference, signed
  localparam int SQ_W   = 66;   // square of a difference magnitude
  localparam int SUM_W  = 67;   // sum of three squares
  localparam int RAD_W  = 70;   // radicand padded to whole bit pairs
  localparam int ROOT_W = 35;   // integer square root
  localparam int REM_W  = 37;   // square root partial remainder
  localparam int K_W    = 32;
  localparam int REST_W = 31;
  localparam int EMAG_W = 34;   // |length - rest|
  localparam int OUT_W  = 32;
  // sideband carried through the square root: three magnitudes, three signs, k, rest
  localparam int SIDE_W = LANES * D_W + LANES + K_W + REST_W;
endpackage

>>> rtl/sfd_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module sfd_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [sfd_pkg::RAD_W-1:0]    radicand,
  input  logic [sfd_pkg::SIDE_W-1:0]   side_in,
  output logic                         out_valid,
  output logic [sfd_pkg::ROOT_W-1:0]   root,
  output logic [sfd_pkg::SIDE_W-1:0]   side_out
);
  localparam int NB = sfd_pkg::ROOT_W;
  localparam int RW = sfd_pkg::REM_W;

  logic                        v_r    [NB];
  logic [RW-1:0]               rem_r  [NB];
  logic [NB-1:0]               root_r [NB];
  logic [sfd_pkg::RAD_W-1:0]   rad_r  [NB];
  logic [sfd_pkg::SIDE_W-1:0]  side_r [NB];

  genvar i;
  generate
    for (i = 0; i < NB; i++) begin : g_stage
      logic                        v_in;
      logic [RW-1:0]               rem_in;
      logic [NB-1:0]               root_in;
      logic [sfd_pkg::RAD_W-1:0]   rad_in;
      logic [sfd_pkg::SIDE_W-1:0]  side_in_s;
      logic [RW-1:0]               rem_sh;
      logic [RW-1:0]               trial;
      logic                        take;
      logic [RW-1:0]               rem_nxt;
      logic [NB-1:0]               root_nxt;

      if (i == 0) begin : g_first
        assign v_in      = in_valid;
        assign rem_in    = '0;
        assign root_in   = '0;
        assign rad_in    = radicand;
        assign side_in_s = side_in;
      end else begin : g_next
        assign v_in      = v_r[i-1];
        assign rem_in    = rem_r[i-1];
        assign root_in   = root_r[i-1];
        assign rad_in    = rad_r[i-1];
        assign side_in_s = side_r[i-1];
      end

      // bring down the next bit pair and try root*4+1
      always_comb begin
        rem_sh   = {rem_in[RW-3:0], rad_in[2*(NB-1-i)+1 -: 2]};
        trial    = {root_in, 2'b01};
        take     = (rem_sh >= trial);
        rem_nxt  = take ? (rem_sh - trial) : rem_sh;
        root_nxt = {root_in[NB-2:0], take};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else begin
          v_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        rad_r[i]  <= rad_in;
        side_r[i] <= side_in_s;
      end
    end
  endgenerate

  assign out_valid = v_r[NB-1];
  assign root      = root_r[NB-1];
  assign side_out  = side_r[NB-1];
endmodule

>>> rtl/sfd_div.sv
// Pipelined restoring divider: (dm << FRAC_BITS) / len, quotient of FRAC_BITS+1 bits.
module sfd_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic [sfd_pkg::D_W-1:0]     dm,
  input  logic [sfd_pkg::ROOT_W-1:0]  len,
  output logic [FRAC_BITS:0]          quot
);
  localparam int NS = FRAC_BITS + 1;
  localparam int RW = sfd_pkg::ROOT_W + 1;

  logic [RW-1:0]               r_r   [NS];
  logic [FRAC_BITS:0]          q_r   [NS];
  logic [sfd_pkg::ROOT_W-1:0]  len_r [NS];

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_stage
      logic [RW-1:0]               r_in;
      logic [FRAC_BITS:0]          q_in;
      logic [sfd_pkg::ROOT_W-1:0]  len_in;
      logic [RW-1:0]               diff;
      logic                        take;

      if (i == 0) begin : g_first
        assign r_in   = RW'(dm);
        assign q_in   = '0;
        assign len_in = len;
      end else begin : g_next
        assign r_in   = r_r[i-1];
        assign q_in   = q_r[i-1];
        assign len_in = len_r[i-1];
      end

      always_comb begin
        take = (r_in >= {1'b0, len_in});
        diff = take ? (r_in - {1'b0, len_in}) : r_in;
      end

      // keep the remainder below len, then shift in the next zero numerator bit
      always_ff @(posedge clk) begin
        r_r[i]   <= {diff[RW-2:0], 1'b0};
        q_r[i]   <= {q_in[FRAC_BITS-1:0], take};
        len_r[i] <= len_in;
      end
    end
  endgenerate

  assign quot = q_r[NS-1];
endmodule

>>> rtl/spring_force_3d.sv
// Top level: streaming Hooke spring force generator for one spring per item.
//
//  channel  ports                              handshake
//  -------  ---------------------------------  ------------------------------
//  input    in_self_pos_*, in_other_pos_*,     taken when start=1 and busy=0
//           in_spring_constant, in_rest_length
//  result   out_self_force_*, out_other_force_*, one cycle, marked by out_valid
//           out_saturated
//
//  Cycles: one item per clock; each item passes 3 front stages, 35 square
//  root stages, FRAC_BITS+1 divider stages with the stiffness product beside
//  them, and 3 output stages.
//  The square root, one bit per stage, sets most of the latency.
//  Reset: synchronous, active low; clears the valid bits only.
//  Stalls: none. busy stays low and results cannot be held off, so the
//  pipeline advances every cycle.
module spring_force_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  in_self_pos_x,
  input  logic signed [31:0]                  in_self_pos_y,
  input  logic signed [31:0]                  in_self_pos_z,
  input  logic signed [31:0]                  in_other_pos_x,
  input  logic signed [31:0]                  in_other_pos_y,
  input  logic signed [31:0]                  in_other_pos_z,
  input  logic signed [31:0]                  in_spring_constant,
  input  logic [30:0]                         in_rest_length,
  output logic                                out_valid,
  output logic signed [31:0]                  out_self_force_x,
  output logic signed [31:0]                  out_self_force_y,
  output logic signed [31:0]                  out_self_force_z,
  output logic signed [31:0]                  out_other_force_x,
  output logic signed [31:0]                  out_other_force_y,
  output logic signed [31:0]                  out_other_force_z,
  output logic                                out_saturated
);
  localparam int L    = sfd_pkg::LANES;
  localparam int DW   = sfd_pkg::D_W;
  localparam int MW   = 66 - FRAC_BITS;           // |m| width
  localparam int MHW  = MW - 32;                  // high part of |m|
  localparam int NW   = FRAC_BITS + 1;            // |n| width
  localparam int PHW  = MHW + NW;
  localparam int PLW  = 32 + NW;
  localparam int TW   = PHW + 32;                 // full |m|*|n|
  localparam int FW   = TW - FRAC_BITS;           // |F| width
  localparam int DL   = FRAC_BITS - 1;            // delay to meet the divider

  assign busy = 1'b0;

  // ---------------- front: differences, squares, sum
  logic                    v1_r, v2_r, v3_r;
  logic signed [DW-1:0]    d_r   [L];
  logic signed [31:0]      k1_r, k2_r, k3_r;
  logic [30:0]             rest1_r, rest2_r, rest3_r;
  logic [DW-1:0]           dm2_r [L];
  logic [DW-1:0]           dm3_r [L];
  logic [L-1:0]            neg2_r, neg3_r;
  logic [sfd_pkg::SQ_W-1:0]  sq_r [L];
  logic [sfd_pkg::SUM_W-1:0] s_r;

  logic signed [31:0] self_p  [L];
  logic signed [31:0] other_p [L];
  assign self_p[0]  = in_self_pos_x;
  assign self_p[1]  = in_self_pos_y;
  assign self_p[2]  = in_self_pos_z;
  assign other_p[0] = in_other_pos_x;
  assign other_p[1] = in_other_pos_y;
  assign other_p[2] = in_other_pos_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      d_r[i] <= DW'(self_p[i]) - DW'(other_p[i]);
    end
    k1_r    <= in_spring_constant;
    rest1_r <= in_rest_length;
  end

  // take magnitudes and square them
  logic [DW-1:0] dm1 [L];
  always_comb begin
    for (int i = 0; i < L; i++) begin
      dm1[i] = d_r[i][DW-1] ? DW'(-d_r[i]) : DW'(d_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      dm2_r[i]  <= dm1[i];
      neg2_r[i] <= d_r[i][DW-1];
      sq_r[i]   <= sfd_pkg::SQ_W'(dm1[i]) * sfd_pkg::SQ_W'(dm1[i]);
    end
    k2_r    <= k1_r;
    rest2_r <= rest1_r;
  end

  always_ff @(posedge clk) begin
    s_r     <= sfd_pkg::SUM_W'(sq_r[0]) + sfd_pkg::SUM_W'(sq_r[1])
             + sfd_pkg::SUM_W'(sq_r[2]);
    dm3_r   <= dm2_r;
    neg3_r  <= neg2_r;
    k3_r    <= k2_r;
    rest3_r <= rest2_r;
  end

  // ---------------- length
  logic                        sq_v;
  logic [sfd_pkg::ROOT_W-1:0]  len;
  logic [sfd_pkg::SIDE_W-1:0]  side_o;

  sfd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .radicand  (sfd_pkg::RAD_W'(s_r)),
    .side_in   ({dm3_r[2], dm3_r[1], dm3_r[0], neg3_r, k3_r, rest3_r}),
    .out_valid (sq_v),
    .root      (len),
    .side_out  (side_o)
  );

  logic [DW-1:0]      dm_s [L];
  logic [L-1:0]       neg_s;
  logic signed [31:0] k_s;
  logic [30:0]        rest_s;
  assign dm_s[2] = side_o[sfd_pkg::SIDE_W-1 -: DW];
  assign dm_s[1] = side_o[sfd_pkg::SIDE_W-1-DW -: DW];
  assign dm_s[0] = side_o[sfd_pkg::SIDE_W-1-2*DW -: DW];
  assign neg_s   = side_o[63 +: L];
  assign k_s     = side_o[31 +: 32];
  assign rest_s  = side_o[30:0];

  // ---------------- direction: three divider lanes
  logic [NW-1:0] nmag [L];
  genvar g;
  generate
    for (g = 0; g < L; g++) begin : g_lane
      sfd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk  (clk),
        .dm   (dm_s[g]),
        .len  (len),
        .quot (nmag[g])
      );
    end
  endgenerate

  // ---------------- magnitude of m beside the dividers
  logic                         p1_v_r, p2_v_r;
  logic [sfd_pkg::EMAG_W-1:0]   emag_r;
  logic [31:0]                  kmag_r;
  logic                         mneg1_r, mneg2_r;
  logic                         zero1_r, zero2_r;
  logic [L-1:0]                 pneg1_r, pneg2_r;
  logic [MW-1:0]                mmag_r;
  logic signed [35:0]           e_full;
  logic [65:0]                  mprod;

  assign e_full = $signed({1'b0, len}) - $signed({5'b0, rest_s});
  assign mprod  = 66'(kmag_r) * 66'(emag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= sq_v;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    emag_r  <= e_full[35] ? sfd_pkg::EMAG_W'(-e_full) : sfd_pkg::EMAG_W'(e_full);
    kmag_r  <= k_s[31] ? 32'(-k_s) : 32'(k_s);
    mneg1_r <= k_s[31] ^ e_full[35];
    zero1_r <= (len == '0);
    pneg1_r <= neg_s;
    mmag_r  <= mprod[65:FRAC_BITS];
    mneg2_r <= mneg1_r;
    zero2_r <= zero1_r;
    pneg2_r <= pneg1_r;
  end

  // hold m alongside until the quotients arrive
  logic          dv_r    [DL];
  logic [MW-1:0] dmag_r  [DL];
  logic          dmneg_r [DL];
  logic          dzero_r [DL];
  logic [L-1:0]  dneg_r  [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) dv_r[i] <= 1'b0;
    end else begin
      dv_r[0] <= p2_v_r;
      for (int i = 1; i < DL; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    dmag_r[0]  <= mmag_r;
    dmneg_r[0] <= mneg2_r;
    dzero_r[0] <= zero2_r;
    dneg_r[0]  <= pneg2_r;
    for (int i = 1; i < DL; i++) begin
      dmag_r[i]  <= dmag_r[i-1];
      dmneg_r[i] <= dmneg_r[i-1];
      dzero_r[i] <= dzero_r[i-1];
      dneg_r[i]  <= dneg_r[i-1];
    end
  end

  // ---------------- force magnitude: |m|*|n| in two partial products
  logic           q1_v_r, q2_v_r;
  logic [PHW-1:0] ph_r [L];
  logic [PLW-1:0] pl_r [L];
  logic [FW-1:0]  fmag_r [L];
  logic           mneg_q1_r, mneg_q2_r, zero_q1_r, zero_q2_r;
  logic [L-1:0]   neg_q1_r, neg_q2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r    <= 1'b0;
      q2_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      q1_v_r    <= dv_r[DL-1];
      q2_v_r    <= q1_v_r;
      out_valid <= q2_v_r;
    end
  end

  logic [TW-1:0] total [L];
  always_comb begin
    for (int i = 0; i < L; i++) begin
      total[i] = {ph_r[i], 32'b0} + TW'(pl_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      ph_r[i]   <= PHW'(dmag_r[DL-1][MW-1:32]) * PHW'(nmag[i]);
      pl_r[i]   <= PLW'(dmag_r[DL-1][31:0]) * PLW'(nmag[i]);
      fmag_r[i] <= total[i][TW-1:FRAC_BITS];
    end
    mneg_q1_r <= dmneg_r[DL-1];
    zero_q1_r <= dzero_r[DL-1];
    neg_q1_r  <= dneg_r[DL-1];
    mneg_q2_r <= mneg_q1_r;
    zero_q2_r <= zero_q1_r;
    neg_q2_r  <= neg_q1_r;
  end

  // ---------------- clamp both ends and register the result
  logic [31:0] self_nxt  [L];
  logic [31:0] other_nxt [L];
  logic        sat_nxt;

  always_comb begin
    logic fneg;
    logic big;
    logic eqmin;
    sat_nxt = 1'b0;
    for (int i = 0; i < L; i++) begin
      fneg  = (mneg_q2_r == neg_q2_r[i]);
      big   = |fmag_r[i][FW-1:31];
      eqmin = (fmag_r[i] == (FW'(1) << 31));
      // the negative end may reach -2^31 exactly; the positive end may not
      if (fneg) begin
        self_nxt[i]  = (big && !eqmin) ? 32'h8000_0000 : 32'(-fmag_r[i][31:0]);
        other_nxt[i] = big ? 32'h7FFF_FFFF : fmag_r[i][31:0];
      end else begin
        self_nxt[i]  = big ? 32'h7FFF_FFFF : fmag_r[i][31:0];
        other_nxt[i] = (big && !eqmin) ? 32'h8000_0000 : 32'(-fmag_r[i][31:0]);
      end
      if (big) sat_nxt = 1'b1;
      // drop everything for a zero-length spring
      if (zero_q2_r) begin
        self_nxt[i]  = '0;
        other_nxt[i] = '0;
      end
    end
    if (zero_q2_r) sat_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    out_self_force_x  <= self_nxt[0];
    out_self_force_y  <= self_nxt[1];
    out_self_force_z  <= self_nxt[2];
    out_other_force_x <= other_nxt[0];
    out_other_force_y <= other_nxt[1];
    out_other_force_z <= other_nxt[2];
    out_saturated     <= sat_nxt;
  end
endmodule
